// ----- rtl/tshc_pkg.sv -----
`timescale 1ns / 1ps
// tshc_pkg: shared widths, default sizes and codes for the tour swap hill climb unit
// no dependencies; used by the channel interfaces, the sequencer and the top level
package tshc_pkg;

   localparam int ACTION_BITS = 3;
   localparam int INDEX_BITS  = 10;
   localparam int DVAL_BITS   = 24;
   localparam int STATUS_BITS = 2;
   localparam int LEN_BITS    = 34;
   localparam int CITY_BITS   = 10;
   localparam int COUNT_BITS  = 11;

   localparam int MAX_CITIES_DEF = 1024;
   localparam int DIST_BITS_DEF  = 24;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_WRITE_DIST = 3'd0,
      ACT_WRITE_TOUR = 3'd1,
      ACT_EVALUATE   = 3'd2,
      ACT_TRY_SWAP   = 3'd3,
      ACT_READ_TOUR  = 3'd4
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EQUAL = 2'd2
   } status_type;

endpackage

// ----- rtl/tshc_ifs.sv -----
`timescale 1ns / 1ps
// tshc channel interfaces: request, response and register write channels
// depends on tshc_pkg for the payload widths
interface tshc_req_if;
   import tshc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ACTION_BITS-1:0] action;
   logic [INDEX_BITS-1:0]  first_index;
   logic [INDEX_BITS-1:0]  second_index;
   logic [DVAL_BITS-1:0]   distance_value;
   modport source (output valid, action, first_index, second_index, distance_value,
                   input ready);
   modport sink   (input valid, action, first_index, second_index, distance_value,
                   output ready);
endinterface

interface tshc_rsp_if;
   import tshc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   accepted;
   logic [STATUS_BITS-1:0] status;
   logic [LEN_BITS-1:0]    tour_length;
   logic [CITY_BITS-1:0]   city;
   modport source (output valid, accepted, status, tour_length, city, input ready);
   modport sink   (input valid, accepted, status, tour_length, city, output ready);
endinterface

interface tshc_csr_if;
   import tshc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] city_count;
   modport source (output valid, city_count, input ready);
   modport sink   (input valid, city_count, output ready);
endinterface

// ----- rtl/tshc_ram.sv -----
`timescale 1ns / 1ps
// tshc_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; no dependencies
module tshc_ram #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tshc_ctrl.sv -----
`timescale 1ns / 1ps
// tshc_ctrl: request decode, swap and undo sequencing, tour walk and length accumulation
// depends on tshc_pkg and the tshc channel interfaces; drives the tour and distance rams
module tshc_ctrl #(
   parameter int MAX_CITIES = tshc_pkg::MAX_CITIES_DEF,
   parameter int DIST_BITS  = tshc_pkg::DIST_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tshc_req_if.sink                             req_chan,
   tshc_rsp_if.source                           rsp_chan,
   tshc_csr_if.sink                             csr_chan,
   output logic                                 tour_wr_en,
   output logic [$clog2(MAX_CITIES)-1:0]        tour_wr_addr,
   output logic [tshc_pkg::CITY_BITS-1:0]       tour_wr_data,
   output logic                                 tour_rd_en,
   output logic [$clog2(MAX_CITIES)-1:0]        tour_rd_addr,
   input  logic [tshc_pkg::CITY_BITS-1:0]       tour_rd_data,
   output logic                                 dist_wr_en,
   output logic [2*$clog2(MAX_CITIES)-1:0]      dist_wr_addr,
   output logic [DIST_BITS-1:0]                 dist_wr_data,
   output logic                                 dist_rd_en,
   output logic [2*$clog2(MAX_CITIES)-1:0]      dist_rd_addr,
   input  logic [DIST_BITS-1:0]                 dist_rd_data
);
   import tshc_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_CITIES);
   localparam int CNT_BITS = $clog2(MAX_CITIES + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_SWAP_RD_B,
      ST_SWAP_WR_A,
      ST_SWAP_WR_B,
      ST_WALK,
      ST_UNDO_A,
      ST_UNDO_B,
      ST_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic [IDX_BITS-1:0]  pos_a_ff, pos_a_in;
   logic [IDX_BITS-1:0]  pos_b_ff, pos_b_in;
   logic [CITY_BITS-1:0] ta_ff, ta_in;
   logic [CITY_BITS-1:0] tb_ff, tb_in;
   logic                 swap_ff, swap_in;
   logic [CNT_BITS-1:0]  issue_ff, issue_in;
   logic                 t_vld_ff, t_vld_in;
   logic                 t_first_ff, t_first_in;
   logic                 t_last_ff, t_last_in;
   logic [IDX_BITS-1:0]  first_ff, first_in;
   logic [IDX_BITS-1:0]  prev_ff, prev_in;
   logic                 close_ff, close_in;
   logic                 d_vld_ff, d_vld_in;
   logic                 d_last_ff, d_last_in;
   logic [LEN_BITS-1:0]  sum_ff, sum_in;
   logic                 res_acc_ff, res_acc_in;
   status_type           res_status_ff, res_status_in;
   logic [CITY_BITS-1:0] res_city_ff, res_city_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acc_ff, rsp_acc_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [LEN_BITS-1:0]  rsp_len_ff, rsp_len_in;
   logic [CITY_BITS-1:0] rsp_city_ff, rsp_city_in;

   logic                 req_fire;
   logic                 a_in_tour, b_in_tour, a_in_max, b_in_max;
   logic [IDX_BITS-1:0]  req_a, req_b;
   logic [IDX_BITS-1:0]  walk_city;
   logic [LEN_BITS:0]    sum_wide;
   logic [LEN_BITS-1:0]  sum_next;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign req_a     = IDX_BITS'(req_chan.first_index);
   assign req_b     = IDX_BITS'(req_chan.second_index);
   assign a_in_tour = 32'(req_chan.first_index) < 32'(cnt_ff);
   assign b_in_tour = 32'(req_chan.second_index) < 32'(cnt_ff);
   assign a_in_max  = 32'(req_chan.first_index) < 32'(MAX_CITIES);
   assign b_in_max  = 32'(req_chan.second_index) < 32'(MAX_CITIES);
   assign walk_city = IDX_BITS'(tour_rd_data);

   // running sum saturates at the top of the length range
   assign sum_wide = {1'b0, sum_ff} + (LEN_BITS+1)'(dist_rd_data);
   assign sum_next = sum_wide[LEN_BITS] ? {LEN_BITS{1'b1}} : sum_wide[LEN_BITS-1:0];

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.accepted = rsp_acc_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.tour_length = rsp_len_ff;
   assign rsp_chan.city     = rsp_city_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      len_in        = len_ff;
      pos_a_in      = pos_a_ff;
      pos_b_in      = pos_b_ff;
      ta_in         = ta_ff;
      tb_in         = tb_ff;
      swap_in       = swap_ff;
      issue_in      = issue_ff;
      t_vld_in      = 1'b0;
      t_first_in    = t_first_ff;
      t_last_in     = t_last_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      close_in      = close_ff;
      d_vld_in      = 1'b0;
      d_last_in     = d_last_ff;
      sum_in        = sum_ff;
      res_acc_in    = res_acc_ff;
      res_status_in = res_status_ff;
      res_city_in   = res_city_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_acc_in    = rsp_acc_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_city_in   = rsp_city_ff;

      tour_wr_en   = 1'b0;
      tour_wr_addr = pos_a_ff;
      tour_wr_data = ta_ff;
      tour_rd_en   = 1'b0;
      tour_rd_addr = pos_a_ff;
      dist_wr_en   = 1'b0;
      dist_wr_addr = {req_a, req_b};
      dist_wr_data = DIST_BITS'(req_chan.distance_value);
      dist_rd_en   = 1'b0;
      dist_rd_addr = {prev_ff, walk_city};

      if (csr_chan.valid) begin
         if (32'(csr_chan.city_count) < 32'd2) begin
            cnt_in = CNT_BITS'(2);
         end else if (32'(csr_chan.city_count) > 32'(MAX_CITIES)) begin
            cnt_in = CNT_BITS'(MAX_CITIES);
         end else begin
            cnt_in = CNT_BITS'(csr_chan.city_count);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_acc_in    = 1'b0;
               res_status_in = STATUS_OK;
               res_city_in   = '0;
               pos_a_in      = req_a;
               pos_b_in      = req_b;
               issue_in      = '0;
               sum_in        = '0;
               close_in      = 1'b0;
               state_in      = ST_RESP;
               case (action_type'(req_chan.action))
                  ACT_WRITE_DIST: begin
                     if (a_in_max && b_in_max) begin
                        dist_wr_en = 1'b1;
                     end else begin
                        res_status_in = STATUS_RANGE;
                     end
                  end
                  ACT_WRITE_TOUR: begin
                     if (a_in_tour && b_in_max) begin
                        tour_wr_en   = 1'b1;
                        tour_wr_addr = req_a;
                        tour_wr_data = req_chan.second_index;
                     end else begin
                        res_status_in = STATUS_RANGE;
                     end
                  end
                  ACT_EVALUATE: begin
                     swap_in  = 1'b0;
                     state_in = ST_WALK;
                  end
                  ACT_TRY_SWAP: begin
                     if (!(a_in_tour && b_in_tour)) begin
                        res_status_in = STATUS_RANGE;
                     end else if (req_chan.first_index == req_chan.second_index) begin
                        res_status_in = STATUS_EQUAL;
                     end else begin
                        swap_in      = 1'b1;
                        tour_rd_en   = 1'b1;
                        tour_rd_addr = req_a;
                        state_in     = ST_SWAP_RD_B;
                     end
                  end
                  ACT_READ_TOUR: begin
                     if (a_in_tour) begin
                        tour_rd_en   = 1'b1;
                        tour_rd_addr = req_a;
                        state_in     = ST_READ_WAIT;
                     end else begin
                        res_status_in = STATUS_RANGE;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_RANGE;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            res_city_in = tour_rd_data;
            state_in    = ST_RESP;
         end
         ST_SWAP_RD_B: begin
            tour_rd_en   = 1'b1;
            tour_rd_addr = pos_b_ff;
            ta_in        = tour_rd_data;
            state_in     = ST_SWAP_WR_A;
         end
         ST_SWAP_WR_A: begin
            tb_in        = tour_rd_data;
            tour_wr_en   = 1'b1;
            tour_wr_addr = pos_a_ff;
            tour_wr_data = tour_rd_data;
            state_in     = ST_SWAP_WR_B;
         end
         ST_SWAP_WR_B: begin
            tour_wr_en   = 1'b1;
            tour_wr_addr = pos_b_ff;
            tour_wr_data = ta_ff;
            state_in     = ST_WALK;
         end
         ST_WALK: begin
            // stage one: fetch tour slots in order
            if (issue_ff < cnt_ff) begin
               tour_rd_en   = 1'b1;
               tour_rd_addr = IDX_BITS'(issue_ff);
               issue_in     = issue_ff + CNT_BITS'(1);
               t_vld_in     = 1'b1;
               t_first_in   = (issue_ff == '0);
               t_last_in    = (issue_ff == cnt_ff - CNT_BITS'(1));
            end
            // stage two: look up the leg into each city, then the closing leg
            if (t_vld_ff) begin
               prev_in = walk_city;
               if (t_first_ff) begin
                  first_in = walk_city;
               end else begin
                  dist_rd_en   = 1'b1;
                  dist_rd_addr = {prev_ff, walk_city};
                  d_vld_in     = 1'b1;
                  d_last_in    = 1'b0;
               end
               if (t_last_ff) begin
                  close_in = 1'b1;
               end
            end else if (close_ff) begin
               dist_rd_en   = 1'b1;
               dist_rd_addr = {prev_ff, first_ff};
               d_vld_in     = 1'b1;
               d_last_in    = 1'b1;
               close_in     = 1'b0;
            end
            // stage three: accumulate and decide
            if (d_vld_ff) begin
               sum_in = sum_next;
               if (d_last_ff) begin
                  if (!swap_ff) begin
                     len_in   = sum_next;
                     state_in = ST_RESP;
                  end else if (sum_next < len_ff) begin
                     len_in     = sum_next;
                     res_acc_in = 1'b1;
                     state_in   = ST_RESP;
                  end else begin
                     state_in = ST_UNDO_A;
                  end
               end
            end
         end
         ST_UNDO_A: begin
            tour_wr_en   = 1'b1;
            tour_wr_addr = pos_a_ff;
            tour_wr_data = ta_ff;
            state_in     = ST_UNDO_B;
         end
         ST_UNDO_B: begin
            tour_wr_en   = 1'b1;
            tour_wr_addr = pos_b_ff;
            tour_wr_data = tb_ff;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = res_acc_ff;
               rsp_status_in = res_status_ff;
               rsp_len_in    = len_ff;
               rsp_city_in   = res_city_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= CNT_BITS'(2);
         len_ff       <= '0;
         t_vld_ff     <= 1'b0;
         close_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
         t_vld_ff     <= t_vld_in;
         close_ff     <= close_in;
         d_vld_ff     <= d_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_a_ff      <= pos_a_in;
      pos_b_ff      <= pos_b_in;
      ta_ff         <= ta_in;
      tb_ff         <= tb_in;
      swap_ff       <= swap_in;
      issue_ff      <= issue_in;
      t_first_ff    <= t_first_in;
      t_last_ff     <= t_last_in;
      first_ff      <= first_in;
      prev_ff       <= prev_in;
      d_last_ff     <= d_last_in;
      sum_ff        <= sum_in;
      res_acc_ff    <= res_acc_in;
      res_status_ff <= res_status_in;
      res_city_ff   <= res_city_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_city_ff   <= rsp_city_in;
   end

endmodule

// ----- rtl/tour_swap_hill_climb_unit.sv -----
`timescale 1ns / 1ps
// tour_swap_hill_climb_unit: top level, sequencer plus tour ram and distance ram
// depends on tshc_pkg, the tshc channel interfaces, tshc_ram and tshc_ctrl
//
// usage: requests arrive on req_chan (valid/ready), one response per request leaves on
// rsp_chan (valid/ready), and csr_chan writes the city count, always ready; write it
// only while no request is in flight.
// a request is taken only while the sequencer is idle, one at a time. response valid
// is registered from the response state, entered straight from idle for writes, rejected
// requests and equal swap positions, and through a read wait state for a tour read.
// evaluate walks the whole tour through the tour ram read port, one leg per cycle.
// a swap adds a read and write of both slots in front of the walk and, when the swap
// is not kept, two restoring writes.
// the response sits in an output register; a new request is still taken while it
// waits, and that one finishes its work and holds in the sequencer until the
// receiver takes the earlier response.
// reset clears the sequencer, the stored tour length and sets the city count to 2;
// tour and distance ram contents are not cleared and must be written before use.
module tour_swap_hill_climb_unit #(
   parameter int MAX_CITIES = tshc_pkg::MAX_CITIES_DEF,
   parameter int DIST_BITS  = tshc_pkg::DIST_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   tshc_req_if.sink   req_chan,
   tshc_rsp_if.source rsp_chan,
   tshc_csr_if.sink   csr_chan
);
   import tshc_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_CITIES);

   logic                  tour_wr_en;
   logic [IDX_BITS-1:0]   tour_wr_addr;
   logic [CITY_BITS-1:0]  tour_wr_data;
   logic                  tour_rd_en;
   logic [IDX_BITS-1:0]   tour_rd_addr;
   logic [CITY_BITS-1:0]  tour_rd_data;
   logic                  dist_wr_en;
   logic [2*IDX_BITS-1:0] dist_wr_addr;
   logic [DIST_BITS-1:0]  dist_wr_data;
   logic                  dist_rd_en;
   logic [2*IDX_BITS-1:0] dist_rd_addr;
   logic [DIST_BITS-1:0]  dist_rd_data;

   tshc_ctrl #(
      .MAX_CITIES (MAX_CITIES),
      .DIST_BITS  (DIST_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_chan     (csr_chan),
      .tour_wr_en   (tour_wr_en),
      .tour_wr_addr (tour_wr_addr),
      .tour_wr_data (tour_wr_data),
      .tour_rd_en   (tour_rd_en),
      .tour_rd_addr (tour_rd_addr),
      .tour_rd_data (tour_rd_data),
      .dist_wr_en   (dist_wr_en),
      .dist_wr_addr (dist_wr_addr),
      .dist_wr_data (dist_wr_data),
      .dist_rd_en   (dist_rd_en),
      .dist_rd_addr (dist_rd_addr),
      .dist_rd_data (dist_rd_data)
   );

   tshc_ram #(
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (CITY_BITS)
   ) u_tour_ram (
      .clock   (clock),
      .wr_en   (tour_wr_en),
      .wr_addr (tour_wr_addr),
      .wr_data (tour_wr_data),
      .rd_en   (tour_rd_en),
      .rd_addr (tour_rd_addr),
      .rd_data (tour_rd_data)
   );

   tshc_ram #(
      .ADDR_BITS (2*IDX_BITS),
      .DATA_BITS (DIST_BITS)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr_en),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_en   (dist_rd_en),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd_data)
   );

endmodule
